// ===== rtl/art_pkg.sv =====
// Package for the address region table: beat types, region entry layout and codes.
// Depends on nothing; used by address_region_table.
package art_pkg;

  localparam int ENTRIES   = 16;
  localparam int PAGE_BITS = 12;
  localparam int ADDR_W    = 48;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);

  localparam logic [ADDR_W-1:0] PAGE_SPAN      = ADDR_W'(1) << PAGE_BITS;
  localparam logic [ADDR_W-1:0] PAGE_MASK      = PAGE_SPAN - ADDR_W'(1);
  localparam logic [ADDR_W-1:0] MMAP_BASE_INIT = 48'h7000_0000_0000;

  // Operation codes.
  localparam logic [1:0] OP_MAP    = 2'd0;
  localparam logic [1:0] OP_MMAP   = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_UNMAP  = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERLAP   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BAD       = 3'd4;
  localparam logic [2:0] ST_PARTIAL   = 3'd5;

  // Backing types.
  localparam logic [2:0] KIND_DATA   = 3'd0;
  localparam logic [2:0] KIND_ANON   = 3'd1;
  localparam logic [2:0] KIND_DEVICE = 3'd2;
  localparam logic [2:0] KIND_SHARED = 3'd3;
  localparam logic [2:0] KIND_FILE   = 3'd4;

  typedef struct packed {
    logic [1:0]        operation;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] length;
    logic [7:0]        perm;
    logic [2:0]        object_type;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] region_start;
    logic [ADDR_W-1:0] region_size;
    logic [7:0]        region_perm;
    logic              region_is_device;
    logic [2:0]        region_type;
  } out_beat_t;

  // One stored region; the inclusive last address is kept so the scan needs no adder.
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] last;
    logic [7:0]        perm;
    logic [2:0]        kind;
  } ent_t;

endpackage

// ===== rtl/address_region_table.sv =====
// Top level of the address region table: region memory, scan sequencer and result register.
// Depends on art_pkg for beat types, entry layout and codes.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   art_pkg::in_beat_t  (one operation)
//   out_     output     out_valid/out_stall art_pkg::out_beat_t (one result per operation)
//   cfg_     input      cfg_valid/cfg_ready 48-bit mmap base
//
// An operation is accepted in S_IDLE, then S_SCAN streams every entry out of the region
// memory's single read port, and S_FIN commits and loads the result register. A bad
// type, length or range skips the scan and goes straight to S_FIN. rst_n (synchronous,
// active low) clears the valid bits and loads the default mmap base, so no clearing
// pass is needed.
// A stalled result holds its register while the next operation scans; only the commit waits.
module address_region_table (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  art_pkg::in_beat_t        in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output art_pkg::out_beat_t       out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [art_pkg::ADDR_W-1:0] cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam int AW = art_pkg::ADDR_W;
  localparam int IW = art_pkg::IDX_W;
  localparam int CW = art_pkg::CNT_W;

  logic [1:0] state_r, state_nxt;

  // Region storage: payload in a synchronous memory, valid bits in flops.
  art_pkg::ent_t mem [art_pkg::ENTRIES];
  art_pkg::ent_t rd_data_r;
  logic [IW-1:0] rd_addr;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  art_pkg::ent_t mem_wdata;

  logic [art_pkg::ENTRIES-1:0] valid_r, valid_nxt;
  logic [AW-1:0]               cursor_r, cursor_nxt;

  // Scan pipeline: issue counter, and tag of the entry whose data is in rd_data_r.
  logic [CW-1:0] rd_cnt_r, rd_cnt_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [IW-1:0] rd_tag_r, rd_tag_nxt;

  // Latched request.
  logic [1:0]    req_op_r, req_op_nxt;
  logic [AW-1:0] req_addr_r, req_addr_nxt;
  logic [AW-1:0] req_start_r, req_start_nxt;
  logic [AW-1:0] req_len_r, req_len_nxt;
  logic [AW-1:0] req_last_r, req_last_nxt;
  logic [7:0]    req_perm_r, req_perm_nxt;
  logic [2:0]    req_kind_r, req_kind_nxt;
  logic          req_err_r, req_err_nxt;

  // Scan findings.
  logic          ovl_r, ovl_nxt;
  logic          free_found_r, free_found_nxt;
  logic [IW-1:0] free_idx_r, free_idx_nxt;
  logic          hold_found_r, hold_found_nxt;
  logic [IW-1:0] hold_idx_r, hold_idx_nxt;
  art_pkg::ent_t hold_ent_r, hold_ent_nxt;

  logic               out_valid_r, out_valid_nxt;
  art_pkg::out_beat_t out_data_r, out_data_nxt;

  // Request preparation in the accept cycle.
  logic          in_fire;
  logic          is_map, is_mmap, mmap_bad;
  logic [AW-1:0] prep_start, prep_len;
  logic [AW:0]   prep_last;
  logic          can_load;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  // An offered input beat goes first; a base write waits until the block is idle
  // with no input beat pending.
  assign cfg_ready = (state_r == S_IDLE) && !in_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign can_load  = !out_valid_r || !out_stall;

  always_comb begin
    is_map   = (in_data.operation == art_pkg::OP_MAP);
    is_mmap  = (in_data.operation == art_pkg::OP_MMAP);
    mmap_bad = !(in_data.object_type == art_pkg::KIND_ANON ||
                 in_data.object_type == art_pkg::KIND_SHARED ||
                 in_data.object_type == art_pkg::KIND_FILE) ||
               (in_data.length == '0) ||
               ((in_data.length & art_pkg::PAGE_MASK) != '0);
    // A fixed map is rounded down to a page and raised to at least one page.
    prep_start = is_mmap ? cursor_r : (in_data.address & ~art_pkg::PAGE_MASK);
    prep_len   = (is_map && in_data.length < art_pkg::PAGE_SPAN) ? art_pkg::PAGE_SPAN
                                                                 : in_data.length;
    prep_last  = {1'b0, prep_start} + {1'b0, prep_len} - (AW+1)'(1);
  end

  // The memory is only written in the commit cycle, after the whole scan of the
  // same operation, and the next scan starts later, so reads never meet a
  // pending write and no forwarding is needed.
  assign rd_addr = rd_cnt_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    cursor_nxt     = cursor_r;
    rd_cnt_nxt     = rd_cnt_r;
    rd_vld_nxt     = 1'b0;
    rd_tag_nxt     = rd_tag_r;
    req_op_nxt     = req_op_r;
    req_addr_nxt   = req_addr_r;
    req_start_nxt  = req_start_r;
    req_len_nxt    = req_len_r;
    req_last_nxt   = req_last_r;
    req_perm_nxt   = req_perm_r;
    req_kind_nxt   = req_kind_r;
    req_err_nxt    = req_err_r;
    ovl_nxt        = ovl_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    hold_found_nxt = hold_found_r;
    hold_idx_nxt   = hold_idx_r;
    hold_ent_nxt   = hold_ent_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = free_idx_r;
    mem_wdata      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_op_nxt     = in_data.operation;
          req_addr_nxt   = in_data.address;
          req_start_nxt  = prep_start;
          req_len_nxt    = prep_len;
          req_last_nxt   = prep_last[AW-1:0];
          req_perm_nxt   = in_data.perm;
          req_kind_nxt   = in_data.object_type;
          req_err_nxt    = (is_map && in_data.object_type > art_pkg::KIND_SHARED) ||
                           (is_mmap && mmap_bad) ||
                           ((is_map || is_mmap) && prep_last[AW]);
          ovl_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          hold_found_nxt = 1'b0;
          rd_cnt_nxt     = '0;
          // The cursor moves once the mmap checks pass, even if the insert fails.
          if (is_mmap && !mmap_bad) begin
            cursor_nxt = cursor_r + prep_len;
          end
          state_nxt = req_err_nxt ? S_FIN : S_SCAN;
        end else if (cfg_valid) begin
          cursor_nxt = cfg_data;
        end
      end

      S_SCAN: begin
        if (rd_cnt_r < CW'(art_pkg::ENTRIES)) begin
          rd_vld_nxt = 1'b1;
          rd_tag_nxt = rd_cnt_r[IW-1:0];
          rd_cnt_nxt = rd_cnt_r + CW'(1);
        end
        if (rd_vld_r) begin
          if (valid_r[rd_tag_r]) begin
            if (!(req_start_r > rd_data_r.last || req_last_r < rd_data_r.start)) begin
              ovl_nxt = 1'b1;
            end
            if (!hold_found_r && req_addr_r >= rd_data_r.start &&
                req_addr_r <= rd_data_r.last) begin
              hold_found_nxt = 1'b1;
              hold_idx_nxt   = rd_tag_r;
              hold_ent_nxt   = rd_data_r;
            end
          end else if (!free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = rd_tag_r;
          end
        end
        // The last entry's data is checked in this cycle, so the commit follows.
        if (rd_cnt_r == CW'(art_pkg::ENTRIES)) begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          state_nxt     = S_IDLE;
          if (req_err_r) begin
            out_data_nxt.status = art_pkg::ST_BAD;
          end else begin
            unique case (req_op_r)
              art_pkg::OP_MAP, art_pkg::OP_MMAP: begin
                if (ovl_r) begin
                  out_data_nxt.status = art_pkg::ST_OVERLAP;
                end else if (!free_found_r) begin
                  out_data_nxt.status = art_pkg::ST_FULL;
                end else begin
                  mem_we                        = 1'b1;
                  mem_waddr                     = free_idx_r;
                  mem_wdata.start               = req_start_r;
                  mem_wdata.size                = req_len_r;
                  mem_wdata.last                = req_last_r;
                  mem_wdata.perm                = req_perm_r;
                  mem_wdata.kind                = req_kind_r;
                  valid_nxt[free_idx_r]         = 1'b1;
                  out_data_nxt.status           = art_pkg::ST_OK;
                  out_data_nxt.region_start     = req_start_r;
                  out_data_nxt.region_size      = req_len_r;
                  out_data_nxt.region_perm      = req_perm_r;
                  out_data_nxt.region_type      = req_kind_r;
                  out_data_nxt.region_is_device = (req_kind_r == art_pkg::KIND_DEVICE);
                end
              end
              art_pkg::OP_LOOKUP, art_pkg::OP_UNMAP: begin
                if (!hold_found_r) begin
                  out_data_nxt.status = art_pkg::ST_NOT_FOUND;
                end else if (req_op_r == art_pkg::OP_UNMAP && req_len_r != '0 &&
                             (req_addr_r != hold_ent_r.start ||
                              req_len_r != hold_ent_r.size)) begin
                  out_data_nxt.status = art_pkg::ST_PARTIAL;
                end else begin
                  if (req_op_r == art_pkg::OP_UNMAP) begin
                    valid_nxt[hold_idx_r] = 1'b0;
                  end
                  out_data_nxt.status           = art_pkg::ST_OK;
                  out_data_nxt.region_start     = hold_ent_r.start;
                  out_data_nxt.region_size      = hold_ent_r.size;
                  out_data_nxt.region_perm      = hold_ent_r.perm;
                  out_data_nxt.region_type      = hold_ent_r.kind;
                  out_data_nxt.region_is_device = (hold_ent_r.kind == art_pkg::KIND_DEVICE);
                end
              end
              default: begin
                out_data_nxt.status = art_pkg::ST_BAD;
              end
            endcase
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      cursor_r    <= art_pkg::MMAP_BASE_INIT;
      rd_cnt_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      cursor_r    <= cursor_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_tag_r     <= rd_tag_nxt;
    req_op_r     <= req_op_nxt;
    req_addr_r   <= req_addr_nxt;
    req_start_r  <= req_start_nxt;
    req_len_r    <= req_len_nxt;
    req_last_r   <= req_last_nxt;
    req_perm_r   <= req_perm_nxt;
    req_kind_r   <= req_kind_nxt;
    req_err_r    <= req_err_nxt;
    ovl_r        <= ovl_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    hold_found_r <= hold_found_nxt;
    hold_idx_r   <= hold_idx_nxt;
    hold_ent_r   <= hold_ent_nxt;
    out_data_r   <= out_data_nxt;
  end

  // A failed operation reports nothing but its status.
  a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != art_pkg::ST_OK) |->
      (out_data_r.region_start == '0 && out_data_r.region_size == '0 &&
       out_data_r.region_perm == '0 && out_data_r.region_type == '0 &&
       !out_data_r.region_is_device))
    else $error("failed result carries region fields");

  // The device flag follows the reported type.
  a_device_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.region_is_device ==
                     (out_data_r.region_type == art_pkg::KIND_DEVICE)))
    else $error("device flag disagrees with region type");

  // Memory reads only return data while a scan is running.
  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_SCAN))
    else $error("read data outside of a scan");

  // The table changes only when an operation commits.
  a_valid_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r != $past(valid_r)) |-> ($past(state_r) == S_FIN && $past(can_load)))
    else $error("valid bits changed outside of a commit");

  // The cursor moves only on an accepted mmap or a configuration write.
  a_cursor_move: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(cursor_r) |->
      ($past(state_r) == S_IDLE && ($past(cfg_valid) ||
       ($past(in_fire) && $past(in_data.operation) == art_pkg::OP_MMAP))))
    else $error("cursor moved without mmap or configuration write");

endmodule
